>>> rtl/reaction_dependency_scanner_unit_assert.svh
// Assertion macros for the reaction dependency scanner.
`ifndef REACTION_DEPENDENCY_SCANNER_UNIT_ASSERT_SVH
`define REACTION_DEPENDENCY_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RDS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rds assertion failed");

// next-cycle implication, checked out of reset
`define RDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rds assertion failed");

`endif

>>> rtl/rds_pkg.sv
// Shared types and constants for the reaction dependency scanner.
`timescale 1ns / 1ps

package rds_pkg;

	localparam int NUM_REACTIONS = 64;
	localparam int IDX_W         = 6;
	localparam int SPC_W         = 12;
	localparam int CNT_W         = 2;
	localparam int ACT_W         = 7;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QREAD,
		ST_QLATCH,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] rc;
		logic [SPC_W-1:0] ra;
		logic [SPC_W-1:0] rb;
		logic [CNT_W-1:0] pc;
		logic [SPC_W-1:0] pa;
		logic [SPC_W-1:0] pb;
	} entry_t;

	typedef struct packed {
		logic load_we;
		logic capture;
		logic rd_query;
		logic qlatch;
		logic scan;
		logic flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic limit_zero;
		logic scan_last;
	} ctrl_sts_t;

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
		sat_cnt = (c == 2'd3) ? 2'd2 : c;
	endfunction

endpackage

>>> rtl/rds_ctrl.sv
// Controller state machine sequencing loads and query scans.
`timescale 1ns / 1ps

module rds_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               op,
	input  rds_pkg::ctrl_sts_t sts,
	output rds_pkg::ctrl_cmd_t cmd,
	output logic               busy
);
	import rds_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_QUERY)) begin
					state_nxt = sts.limit_zero ? ST_FLUSH : ST_QREAD;
				end
			end
			ST_QREAD:  state_nxt = ST_QLATCH;
			ST_QLATCH: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH:  state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		busy        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.load_we = accept && (op == OP_LOAD);
				cmd.capture = accept && (op == OP_QUERY);
			end
			ST_QREAD:  cmd.rd_query = 1'b1;
			ST_QLATCH: cmd.qlatch   = 1'b1;
			ST_SCAN:   cmd.scan     = 1'b1;
			ST_FLUSH:  cmd.flush    = 1'b1;
			default:   busy         = 1'b1;
		endcase
	end

endmodule

>>> rtl/rds_datapath.sv
// Reaction table memory, query registers, match logic and result register.
`timescale 1ns / 1ps

module rds_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rds_pkg::ctrl_cmd_t          cmd,
	output rds_pkg::ctrl_sts_t          sts,
	input  logic                        cfg_we,
	input  logic [rds_pkg::ACT_W-1:0]   cfg_data,
	input  logic [rds_pkg::IDX_W-1:0]   rxn_index,
	input  logic [rds_pkg::CNT_W-1:0]   reactant_count,
	input  logic [rds_pkg::SPC_W-1:0]   reactant_a,
	input  logic [rds_pkg::SPC_W-1:0]   reactant_b,
	input  logic [rds_pkg::CNT_W-1:0]   product_count,
	input  logic [rds_pkg::SPC_W-1:0]   product_a,
	input  logic [rds_pkg::SPC_W-1:0]   product_b,
	output logic                        result_valid,
	output logic [rds_pkg::IDX_W-1:0]   dependent_index,
	output logic                        none_found,
	output logic                        last
);
	import rds_pkg::*;

	entry_t             mem [NUM_REACTIONS];
	entry_t             rd_data_q;
	entry_t             qry_q;
	entry_t             wr_entry;
	logic [IDX_W-1:0]   rd_addr;
	logic [ACT_W-1:0]   active_q;
	logic [ACT_W-1:0]   limit_q;
	logic [IDX_W-1:0]   qidx_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic               pend_vld_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic               res_vld_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_none_q;
	logic               res_last_q;
	logic               hit_a;
	logic               hit_b;
	logic               match;

	function automatic logic hit(input entry_t q, input logic [SPC_W-1:0] s);
		hit = ((q.rc >= 2'd1) && (s == q.ra)) || ((q.rc >= 2'd2) && (s == q.rb)) ||
		      ((q.pc >= 2'd1) && (s == q.pa)) || ((q.pc >= 2'd2) && (s == q.pb));
	endfunction

	always_comb begin
		wr_entry.rc = sat_cnt(reactant_count);
		wr_entry.ra = reactant_a;
		wr_entry.rb = reactant_b;
		wr_entry.pc = sat_cnt(product_count);
		wr_entry.pa = product_a;
		wr_entry.pb = product_b;
	end

	always_comb begin
		if (cmd.rd_query) begin
			rd_addr = qidx_q;
		end else if (cmd.qlatch) begin
			rd_addr = '0;
		end else begin
			rd_addr = cmp_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			mem[rxn_index] <= wr_entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign hit_a = (rd_data_q.rc >= 2'd1) && hit(qry_q, rd_data_q.ra);
	assign hit_b = (rd_data_q.rc >= 2'd2) && hit(qry_q, rd_data_q.rb);
	assign match = hit_a || hit_b;

	assign sts.limit_zero = (active_q == '0);
	assign sts.scan_last  = (({1'b0, cmp_idx_q} + ACT_W'(1)) == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_W'(NUM_REACTIONS);
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qidx_q  <= rxn_index;
			limit_q <= (active_q > ACT_W'(NUM_REACTIONS)) ? ACT_W'(NUM_REACTIONS) : active_q;
		end
		if (cmd.qlatch) begin
			qry_q <= rd_data_q;
		end
		if (cmd.qlatch) begin
			cmp_idx_q <= '0;
		end else if (cmd.scan) begin
			cmp_idx_q <= cmp_idx_q + IDX_W'(1);
		end
		if (cmd.scan && match) begin
			pend_idx_q <= cmp_idx_q;
		end
		if (cmd.scan || cmd.flush) begin
			res_idx_q  <= (cmd.flush && !pend_vld_q) ? '0 : pend_idx_q;
			res_none_q <= cmd.flush && !pend_vld_q;
			res_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				pend_vld_q <= 1'b0;
			end else if (cmd.scan && match) begin
				pend_vld_q <= 1'b1;
			end
			res_vld_q <= cmd.flush || (cmd.scan && match && pend_vld_q);
		end
	end

	assign result_valid    = res_vld_q;
	assign dependent_index = res_idx_q;
	assign none_found      = res_none_q;
	assign last            = res_last_q;

endmodule

>>> rtl/reaction_dependency_scanner_unit.sv
// Top level of the reaction dependency scanner.
//
// channel   signals                                   handshake
// input     start, busy, op, rxn_index, ...           start && !busy
// config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
// result    result_valid, dependent_index, ...        result_valid, one cycle
//
// A load word is written to the table when accepted; busy stays low.
// A query word runs through accept, read of the queried entry, latch, one table entry per
// cycle over min(active_reactions, 64) entries, then a flush. A query with zero active
// entries goes from accept straight to the flush. Each match is held until the next match
// or the flush so the final word carries last; the receiver cannot stall.
// Reset sets active_reactions to 64; table contents are not cleared.
`timescale 1ns / 1ps
`include "reaction_dependency_scanner_unit_assert.svh"

module reaction_dependency_scanner_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [rds_pkg::IDX_W-1:0]   rxn_index,
	input  logic [rds_pkg::CNT_W-1:0]   reactant_count,
	input  logic [rds_pkg::SPC_W-1:0]   reactant_a,
	input  logic [rds_pkg::SPC_W-1:0]   reactant_b,
	input  logic [rds_pkg::CNT_W-1:0]   product_count,
	input  logic [rds_pkg::SPC_W-1:0]   product_a,
	input  logic [rds_pkg::SPC_W-1:0]   product_b,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rds_pkg::ACT_W-1:0]   cfg_data,
	output logic                        result_valid,
	output logic [rds_pkg::IDX_W-1:0]   dependent_index,
	output logic                        none_found,
	output logic                        last
);
	import rds_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	rds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rds_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.rxn_index       (rxn_index),
		.reactant_count  (reactant_count),
		.reactant_a      (reactant_a),
		.reactant_b      (reactant_b),
		.product_count   (product_count),
		.product_a       (product_a),
		.product_b       (product_b),
		.result_valid    (result_valid),
		.dependent_index (dependent_index),
		.none_found      (none_found),
		.last            (last)
	);

	`RDS_ASSERT_IMPL(a_none_is_last, result_valid && none_found, last)
	`RDS_ASSERT_IMPL(a_last_ends_query, result_valid && last, !busy)
	`RDS_ASSERT_IMPL(a_mid_result_busy, result_valid && !last, busy)
	`RDS_ASSERT_NEXT(a_query_goes_busy, start && !busy && (op == OP_QUERY), busy)

endmodule
